FILE: hdl/ilp_pkg.sv
// ilp_pkg: shared types and constants for the integer literal parser
// no dependencies; used by every module of the block

package ilp_pkg;

  // character codes that steer the parse
  localparam logic [7:0] ChDash  = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChQuote = 8'h27;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;

  typedef enum logic [1:0] {
    FORM_DEC   = 2'd0,
    FORM_HEX   = 2'd1,
    FORM_QUOTE = 2'd2
  } form_e;

  // input request
  typedef struct packed {
    logic [7:0] char_in;
    logic       start_new;
  } in_req_t;

  // result request
  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         form;
  } out_req_t;

  // classified byte, passed from front to back
  typedef struct packed {
    logic       start_new;
    logic       is_dash;
    logic       is_zero;
    logic       is_quote;
    logic       is_x;
    logic       is_dec;
    logic       is_hex;
    logic [3:0] digit;
    logic [7:0] chr;
  } token_t;

endpackage

FILE: hdl/ilp_front.sv
// ilp_front: input handshake and byte classification
// depends on ilp_pkg; feeds ilp_queue

module ilp_front (
  input  ilp_pkg::in_req_t in_req_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             q_ready_i,
  output logic             q_push_o,
  output ilp_pkg::token_t  q_token_o
);

  logic [7:0] c;
  logic       is_dec;
  logic       is_upper;
  logic       is_lower;

  assign c        = in_req_i.char_in;
  assign is_dec   = (c >= ilp_pkg::ChZero) && (c <= ilp_pkg::ChNine);
  assign is_upper = (c >= ilp_pkg::ChUpA) && (c <= ilp_pkg::ChUpF);
  assign is_lower = (c >= ilp_pkg::ChLowA) && (c <= ilp_pkg::ChLowF);

  assign in_ready_o = q_ready_i;
  assign q_push_o   = in_valid_i && q_ready_i;

  always_comb begin
    q_token_o           = '0;
    q_token_o.start_new = in_req_i.start_new;
    q_token_o.is_dash   = (c == ilp_pkg::ChDash);
    q_token_o.is_zero   = (c == ilp_pkg::ChZero);
    q_token_o.is_quote  = (c == ilp_pkg::ChQuote);
    q_token_o.is_x      = (c == ilp_pkg::ChLowX) || (c == ilp_pkg::ChUpX);
    q_token_o.is_dec    = is_dec;
    q_token_o.is_hex    = is_dec || is_upper || is_lower;
    q_token_o.chr       = c;
    // one digit value serves both decimal and hex
    priority if (is_dec) begin
      q_token_o.digit = 4'(c - ilp_pkg::ChZero);
    end else if (is_upper) begin
      q_token_o.digit = 4'(c - ilp_pkg::ChUpA + 8'd10);
    end else if (is_lower) begin
      q_token_o.digit = 4'(c - ilp_pkg::ChLowA + 8'd10);
    end else begin
      q_token_o.digit = 4'd0;
    end
  end

endmodule

FILE: hdl/ilp_queue.sv
// ilp_queue: short register queue of classified bytes
// depends on ilp_pkg; sits between ilp_front and ilp_back

module ilp_queue #(
  parameter int Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ilp_pkg::token_t token_i,
  output logic            ready_o,
  input  logic            pop_i,
  output logic            valid_o,
  output ilp_pkg::token_t token_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ilp_pkg::token_t slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign ready_o = (cnt_q != FullCnt);
  assign valid_o = (cnt_q != '0);
  assign token_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= token_i;
    end
  end

endmodule

FILE: hdl/ilp_back.sv
// ilp_back: parse state machine, accumulator and output register
// depends on ilp_pkg; drains ilp_queue

module ilp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  ilp_pkg::token_t   q_token_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ilp_pkg::out_req_t out_req_o
);

  typedef enum logic [5:0] {
    PH_FIRST  = 6'b000001,
    PH_SIGNED = 6'b000010,
    PH_ZERO   = 6'b000100,
    PH_HEX    = 6'b001000,
    PH_DEC    = 6'b010000,
    PH_QUOTE  = 6'b100000
  } phase_e;

  phase_e            phase_q, phase_d, cur_phase;
  logic              neg_q, neg_d, cur_neg;
  logic [31:0]       acc_q, acc_d, cur_acc;
  logic [31:0]       dec_next;
  logic              emit;
  logic [31:0]       mag;
  logic [1:0]        form;
  logic              out_valid_q, out_valid_d;
  ilp_pkg::out_req_t out_req_q;
  ilp_pkg::token_t   tok;

  assign tok         = q_token_i;
  assign q_pop_o     = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  // start flag drops any partial parse
  assign cur_phase = tok.start_new ? PH_FIRST : phase_q;
  assign cur_neg   = tok.start_new ? 1'b0 : neg_q;
  assign cur_acc   = tok.start_new ? 32'd0 : acc_q;
  // acc * 10 + digit
  assign dec_next  = (cur_acc << 3) + (cur_acc << 1) + {28'd0, tok.digit};

  always_comb begin
    phase_d = cur_phase;
    neg_d   = cur_neg;
    acc_d   = cur_acc;
    emit    = 1'b0;
    mag     = cur_acc;
    form    = ilp_pkg::FORM_DEC;
    unique case (cur_phase)
      PH_SIGNED, PH_FIRST: begin
        if (cur_phase == PH_FIRST && tok.is_dash) begin
          neg_d   = 1'b1;
          phase_d = PH_SIGNED;
        end else if (tok.is_zero) begin
          acc_d   = 32'd0;
          phase_d = PH_ZERO;
        end else if (tok.is_quote) begin
          phase_d = PH_QUOTE;
        end else if (tok.is_dec) begin
          acc_d   = {28'd0, tok.digit};
          phase_d = PH_DEC;
        end else begin
          emit = 1'b1;
          mag  = 32'd0;
        end
      end
      PH_ZERO: begin
        if (tok.is_x) begin
          phase_d = PH_HEX;
        end else if (tok.is_dec) begin
          acc_d   = dec_next;
          phase_d = PH_DEC;
        end else begin
          emit = 1'b1;
        end
      end
      PH_HEX: begin
        if (tok.is_hex) begin
          acc_d = {cur_acc[27:0], tok.digit};
        end else begin
          emit = 1'b1;
          form = ilp_pkg::FORM_HEX;
        end
      end
      PH_DEC: begin
        if (tok.is_dec) begin
          acc_d = dec_next;
        end else begin
          emit = 1'b1;
        end
      end
      PH_QUOTE: begin
        emit = 1'b1;
        mag  = {{24{tok.chr[7]}}, tok.chr};
        form = ilp_pkg::FORM_QUOTE;
      end
      default: begin
        // illegal code: restart as if expecting a first character
        neg_d   = 1'b0;
        acc_d   = 32'd0;
        phase_d = PH_FIRST;
      end
    endcase
    if (emit) begin
      phase_d = PH_FIRST;
      neg_d   = 1'b0;
      acc_d   = 32'd0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (q_pop_o && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FIRST;
      neg_q       <= 1'b0;
      acc_q       <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (q_pop_o) begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        acc_q   <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && emit) begin
      out_req_q.value <= cur_neg ? -mag : mag;
      out_req_q.form  <= form;
    end
  end

endmodule

FILE: hdl/integer_literal_parser.sv
// integer_literal_parser: top level of the streaming integer literal parser
// depends on ilp_pkg, ilp_front, ilp_queue and ilp_back

// Takes text one byte per request and parses signed 32-bit integer literals:
// an optional leading '-', then either decimal digits, a "0x"/"0X" prefix with
// hex digits in either case, or a quote followed by one byte whose code (as a
// signed byte) is the value. The first byte that does not fit ends the literal,
// is consumed, and produces one result request with the sign applied and the
// value wrapped modulo 2^32; form tells decimal, hex or quoted character. A
// byte with start_new set throws away any parse in progress and begins a new
// literal. Bytes are taken at one per cycle: the front classifies each byte
// and writes it into a small queue (QueueDepth entries), the back pops one
// entry per cycle through the parse state machine and its accumulate step (one
// shift-add), and writes results into a single output register. A byte that
// ends a literal passes through its queue slot and then the output register
// before its result shows; a stalled output side blocks the back, and the
// queue lets the input side keep going until it fills.

module integer_literal_parser #(
  parameter int QueueDepth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ilp_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ilp_pkg::out_req_t out_req_o
);

  // front to queue
  logic            q_push;
  logic            q_ready;
  ilp_pkg::token_t q_wr_token;

  // queue to back
  logic            q_pop;
  logic            q_valid;
  ilp_pkg::token_t q_rd_token;

  // classify each byte as it is accepted
  ilp_front u_front (
    .in_req_i   (in_req_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_token_o  (q_wr_token)
  );

  // decouples byte intake from result delivery
  ilp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .token_i (q_wr_token),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .token_o (q_rd_token)
  );

  // parse state, accumulator and result register
  ilp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_token_i   (q_rd_token),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule

FILE: dv/ilp_checker.sv
`timescale 1ns / 100ps
// ilp_checker: watches both channels of the integer literal parser, predicts results
// and compares them in order; depends on ilp_pkg only

module ilp_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  ilp_pkg::in_req_t  in_req_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  ilp_pkg::out_req_t out_req_i,
  output int                fail_count_o,
  output int                outstanding_o
);
  import ilp_pkg::*;

  typedef enum logic [2:0] {
    PhFirst, PhSigned, PhZero, PhHex, PhDec, PhQuote
  } parse_phase_e;

  parse_phase_e phase_q    = PhFirst;
  logic         negative_q = 1'b0;
  logic [31:0]  accum_q    = '0;

  out_req_t parsed_values_q[$];
  out_req_t predicted;
  out_req_t oldest;

  initial fail_count_o = 0;
  initial outstanding_o = 0;

  function automatic void clear_literal();
    phase_q    = PhFirst;
    negative_q = 1'b0;
    accum_q    = '0;
  endfunction

  // advances the parse by one byte; returns 1 when the byte closes a literal
  function automatic bit parse_byte(input logic [7:0] c, input logic fresh,
                                    output out_req_t res);
    bit          run_body;
    bit          run_dec;
    bit          closes;
    bit          hex_ok;
    logic [31:0] magnitude;
    logic [3:0]  nibble;
    form_e       kind;
    run_body  = 1'b0;
    run_dec   = 1'b0;
    closes    = 1'b0;
    hex_ok    = 1'b1;
    magnitude = '0;
    nibble    = '0;
    kind      = FORM_DEC;
    res       = '0;
    if (fresh) clear_literal();
    case (phase_q)
      PhSigned: run_body = 1'b1;
      PhZero: begin
        if (c == ChLowX || c == ChUpX) phase_q = PhHex;
        else run_dec = 1'b1;
      end
      PhHex: begin
        if (c >= ChZero && c <= ChNine) nibble = 4'(c - ChZero);
        else if (c >= ChUpA && c <= ChUpF) nibble = 4'(c - ChUpA + 8'd10);
        else if (c >= ChLowA && c <= ChLowF) nibble = 4'(c - ChLowA + 8'd10);
        else hex_ok = 1'b0;
        if (hex_ok) begin
          accum_q = {accum_q[27:0], 4'b0} + {28'b0, nibble};
        end else begin
          magnitude = accum_q;
          kind      = FORM_HEX;
          closes    = 1'b1;
        end
      end
      PhDec: run_dec = 1'b1;
      PhQuote: begin
        magnitude = {{24{c[7]}}, c};
        kind      = FORM_QUOTE;
        closes    = 1'b1;
      end
      default: begin
        clear_literal();
        if (c == ChDash) begin
          negative_q = 1'b1;
          phase_q    = PhSigned;
        end else begin
          run_body = 1'b1;
        end
      end
    endcase
    if (run_body) begin
      if (c == ChZero) begin
        accum_q = '0;
        phase_q = PhZero;
      end else if (c == ChQuote) begin
        phase_q = PhQuote;
      end else begin
        run_dec = 1'b1;
      end
    end
    if (run_dec) begin
      if (c >= ChZero && c <= ChNine) begin
        accum_q = accum_q * 32'd10 + {24'b0, c - ChZero};
        phase_q = PhDec;
      end else begin
        magnitude = accum_q;
        kind      = FORM_DEC;
        closes    = 1'b1;
      end
    end
    if (closes) begin
      res.value = negative_q ? (32'd0 - magnitude) : magnitude;
      res.form  = kind;
      clear_literal();
    end
    return closes;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_literal();
      parsed_values_q.delete();
      outstanding_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (parse_byte(in_req_i.char_in, in_req_i.start_new, predicted))
          parsed_values_q.push_back(predicted);
      end
      if (out_valid_i && out_ready_i) begin
        if (parsed_values_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual value %0d form %0d",
                   $time, out_req_i.value, out_req_i.form);
          fail_count_o++;
        end else begin
          oldest = parsed_values_q.pop_front();
          if (out_req_i.value !== oldest.value) begin
            $display("%0t: value mismatch, expected %0d, actual %0d",
                     $time, oldest.value, out_req_i.value);
            fail_count_o++;
          end
          if (out_req_i.form !== oldest.form) begin
            $display("%0t: form mismatch, expected %0d, actual %0d",
                     $time, oldest.form, out_req_i.form);
            fail_count_o++;
          end
        end
      end
      outstanding_o <= parsed_values_q.size();
    end
  end

endmodule

FILE: dv/integer_literal_parser_tb.sv
`timescale 1ns / 100ps
// integer_literal_parser_tb: drives text bytes into the integer literal parser and
// gives the verdict; depends on ilp_pkg, the block and ilp_checker

module integer_literal_parser_tb;
  import ilp_pkg::*;

  // random bytes sent after the directed part
  localparam int RandomBytes = 1450;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_req_t  in_req    = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_req_t out_req;

  int fail_count;
  int outstanding;

  // shared stimulus controls
  int bytes_sent     = 0;
  bit no_idle        = 1'b0;  // both sides run without gaps while set
  int stall_requests = 0;     // each bump asks the receiver for one long hold-off

  integer_literal_parser DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_req_o   (out_req)
  );

  ilp_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_req_i      (in_req),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_req_i     (out_req),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always #5 clk_i = ~clk_i;

  // single reset at the start of the run
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  // idle length: mostly none, some short, a few long
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // byte that usually ends a literal: a space half the time, else anything
  function automatic logic [7:0] terminator_byte();
    if ($urandom_range(0, 1) == 1) return 8'h20;
    return 8'($urandom_range(0, 255));
  endfunction

  // receiver: random back-pressure, plus a long hold-off whenever one is requested
  initial begin
    int gap;
    int served;
    served = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (served != stall_requests) begin
        // hold the output long enough for the queue to fill and block the input
        served++;
        out_ready <= 1'b0;
        repeat (200) @(posedge clk_i);
        out_ready <= 1'b1;
      end else begin
        gap = idle_cycles();
        if (gap == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
          out_ready <= 1'b1;
        end
      end
    end
  end

  // offer one byte, hold it until accepted, then maybe go idle for a while;
  // valid stays high across back-to-back requests
  task automatic send_byte(input logic [7:0] c, input logic fresh);
    int gap;
    in_valid <= 1'b1;
    in_req   <= '{char_in: c, start_new: fresh};
    do @(posedge clk_i); while (!in_ready);
    bytes_sent++;
    gap = idle_cycles();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // one literal with random content; mostly well formed, some noise, and now and
  // then a start flag that cuts a literal short
  task automatic send_random_literal();
    logic [7:0] text[$];
    string      hex_digits;
    int         kind;
    int         n;
    bit         long_run;
    bit         fresh;
    hex_digits = "0123456789abcdefABCDEF";
    long_run   = ($urandom_range(0, 99) < 15);  // long runs reach the wrap-around
    kind       = $urandom_range(0, 99);
    fresh      = ($urandom_range(0, 9) == 0);
    if ($urandom_range(0, 3) == 0) text.push_back(ChDash);
    if (kind < 40) begin
      // decimal, sometimes with a leading zero
      if ($urandom_range(0, 4) == 0) text.push_back(ChZero);
      n = long_run ? $urandom_range(9, 12) : $urandom_range(1, 4);
      repeat (n) text.push_back(ChZero + 8'($urandom_range(0, 9)));
      text.push_back(terminator_byte());
    end else if (kind < 70) begin
      // hex with either prefix case, digits of mixed case, possibly none
      text.push_back(ChZero);
      text.push_back(($urandom_range(0, 1) == 1) ? ChLowX : ChUpX);
      n = long_run ? $urandom_range(8, 11) : $urandom_range(0, 4);
      repeat (n) text.push_back(hex_digits[$urandom_range(0, 21)]);
      text.push_back(terminator_byte());
    end else if (kind < 85) begin
      // quoted byte, any code
      text.push_back(ChQuote);
      text.push_back(8'($urandom_range(0, 255)));
    end else begin
      // noise
      n = $urandom_range(1, 4);
      repeat (n) text.push_back(8'($urandom_range(0, 255)));
    end
    foreach (text[i]) send_byte(text[i], (i == 0) ? fresh : ($urandom_range(0, 49) == 0));
  endtask

  // main stimulus and verdict
  initial begin
    int stop_at;
    bit stall_done;
    bit pause_done;
    stall_done = 1'b0;
    pause_done = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);

    // directed: signed hex with upper X and mixed digits, then empty hex
    send_text("-0Xa9G");
    send_text("0x ");
    // empty literal after a dash
    send_text("--");
    // lone zero continuing as decimal
    send_text("07z");
    // quoted bytes at both ends of the code range, one negated
    send_byte(ChQuote, 1'b0);
    send_byte(8'hff, 1'b0);
    send_text("-'");
    send_byte(8'h00, 1'b0);
    // start flag drops a partial decimal
    send_text("12");
    send_byte("3", 1'b1);
    send_byte(" ", 1'b0);

    stop_at = bytes_sent + RandomBytes;
    while (bytes_sent < stop_at) begin
      if (!stall_done && bytes_sent >= 400) begin
        // long output hold-off while the sender keeps pushing without gaps
        no_idle = 1'b1;
        stall_requests++;
        stall_done = 1'b1;
      end
      if (!pause_done && bytes_sent >= 900) begin
        // sender pauses until every pending literal has come out
        in_valid <= 1'b0;
        do @(posedge clk_i); while (outstanding != 0);
        pause_done = 1'b1;
      end
      // stretches with and without idling on both sides
      if ($urandom_range(0, 19) == 0) no_idle = !no_idle;
      send_random_literal();
    end

    in_valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    // let any byte still in flight without a result drain through the block
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
